// File: sv/sbsi_pkg.sv
// ----------------------------------------------------------------------------
// sbsi_pkg
// Shared types and constants for the swept box segment intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package sbsi_pkg;

    localparam int TIME_FRAC_BITS = 16;
    localparam int TIME_W         = TIME_FRAC_BITS + 1;

    localparam int COORD_W  = 32;
    localparam int EXT_W    = 31;
    localparam int DIR_W    = COORD_W + 1;
    localparam int BND_W    = COORD_W + 2;
    localparam int MARGIN_W = 12;

    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = (TIME_FRAC_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_LAT    = DIV_STAGES + 1;

    localparam int PROD_W = DIR_W + TIME_W + 1;
    localparam int SHF_W  = PROD_W - TIME_FRAC_BITS;
    localparam int PNT_W  = SHF_W + 1;

    localparam logic [TIME_W-1:0] TIME_ONE = {1'b1, {TIME_FRAC_BITS{1'b0}}};
    localparam logic [TIME_W-1:0] TIME_SAT = TIME_ONE + TIME_W'(1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_MARGIN = 3'd6;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd410;

    localparam logic [1:0] NORM_ZERO = 2'b00;
    localparam logic [1:0] NORM_POS  = 2'b01;
    localparam logic [1:0] NORM_NEG  = 2'b11;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] bmin;
        logic [2:0][COORD_W-1:0] bmax;
        logic [MARGIN_W-1:0]     margin;
    } box_cfg_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] start;
        logic [2:0][COORD_W-1:0] fin;
        logic [2:0][EXT_W-1:0]   ext;
    } seg_in_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] s;
        logic [2:0][DIR_W-1:0]   d;
        logic [2:0][BND_W-1:0]   lo;
        logic [2:0][BND_W-1:0]   hi;
        logic                    miss;
        logic                    enclosed;
        logic [2:0]              face_neg;
    } side_t;

    typedef struct packed {
        logic                    hit;
        logic [2:0][COORD_W-1:0] pt;
        logic [2:0][1:0]         nrm;
        logic [TIME_W-1:0]       t_val;
    } result_t;

endpackage

`default_nettype wire

// File: sv/sbsi_setup.sv
// ----------------------------------------------------------------------------
// sbsi_setup
// Grows the box, forms directions and classifies each axis against its slab.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsi_setup import sbsi_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire seg_in_t  seg,
    input  wire box_cfg_t cfg,
    output logic          out_valid,
    output side_t         side,
    output logic [2:0][COORD_W-1:0] num,
    output logic [2:0][COORD_W-1:0] den
);

    logic                    v1_reg, v2_reg;
    logic [2:0][COORD_W-1:0] s1_reg, s1_next;
    logic [2:0][DIR_W-1:0]   d1_reg, d1_next;
    logic [2:0][BND_W-1:0]   lo1_reg, lo1_next, hi1_reg, hi1_next;
    side_t                   side_reg, side_next;
    logic [2:0][COORD_W-1:0] num_reg, num_next, den_reg, den_next;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            s1_next[a]  = seg.start[a];
            d1_next[a]  = {seg.fin[a][COORD_W-1], seg.fin[a]}
                        - {seg.start[a][COORD_W-1], seg.start[a]};
            lo1_next[a] = {{2{cfg.bmin[a][COORD_W-1]}}, cfg.bmin[a]} - {3'b000, seg.ext[a]};
            hi1_next[a] = {{2{cfg.bmax[a][COORD_W-1]}}, cfg.bmax[a]} + {3'b000, seg.ext[a]};
        end
    end

    always_comb begin
        logic [BND_W-1:0] s_w;
        logic [BND_W-1:0] diff;
        logic [DIR_W-1:0] neg_d;
        logic             below, above;
        side_next          = '0;
        side_next.s        = s1_reg;
        side_next.d        = d1_reg;
        side_next.lo       = lo1_reg;
        side_next.hi       = hi1_reg;
        side_next.enclosed = 1'b1;
        num_next           = '0;
        den_next           = '0;
        diff               = '0;
        for (int a = 0; a < 3; a++) begin
            s_w   = {{2{s1_reg[a][COORD_W-1]}}, s1_reg[a]};
            below = $signed(s_w) < $signed(lo1_reg[a]);
            above = $signed(s_w) > $signed(hi1_reg[a]);
            neg_d = -d1_reg[a];
            den_next[a] = COORD_W'(1);
            if (below) begin
                diff = lo1_reg[a] - s_w;
                num_next[a] = diff[COORD_W-1:0];
                den_next[a] = d1_reg[a][COORD_W-1:0];
                side_next.face_neg[a] = 1'b1;
                side_next.enclosed = 1'b0;
                if (d1_reg[a][DIR_W-1] || d1_reg[a] == '0) begin
                    side_next.miss = 1'b1;
                end
            end else if (above) begin
                diff = s_w - hi1_reg[a];
                num_next[a] = diff[COORD_W-1:0];
                den_next[a] = neg_d[COORD_W-1:0];
                side_next.enclosed = 1'b0;
                if (!d1_reg[a][DIR_W-1]) begin
                    side_next.miss = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= s1_next;
            d1_reg   <= d1_next;
            lo1_reg  <= lo1_next;
            hi1_reg  <= hi1_next;
            side_reg <= side_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
        end
    end

    assign out_valid = v2_reg;
    assign side      = side_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

`default_nettype wire

// File: sv/sbsi_div.sv
// ----------------------------------------------------------------------------
// sbsi_div
// Pipelined restoring divider for one slab entry time, saturating above one.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsi_div import sbsi_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [COORD_W-1:0] num,
    input  wire logic [COORD_W-1:0] den,
    output logic [TIME_W-1:0]       t_val
);

    logic [DIV_STAGES:0][COORD_W-1:0]        r_reg, r_next, den_reg, den_next;
    logic [DIV_STAGES:0][TIME_FRAC_BITS-1:0] fr_reg, fr_next;
    logic [DIV_STAGES:0]                     sat_reg, sat_next, ib_reg, ib_next;

    always_comb begin
        logic [COORD_W:0]          rr;
        logic [COORD_W-1:0]        rem;
        logic [TIME_FRAC_BITS-1:0] fq;
        ib_next[0]  = num >= den;
        sat_next[0] = {1'b0, num} >= {den, 1'b0};
        r_next[0]   = ib_next[0] ? num - den : num;
        den_next[0] = den;
        fr_next[0]  = '0;
        for (int k = 1; k <= DIV_STAGES; k++) begin
            rem = r_reg[k-1];
            fq  = fr_reg[k-1];
            for (int j = 0; j < DIV_BITS; j++) begin
                if ((k - 1) * DIV_BITS + j < TIME_FRAC_BITS) begin
                    rr = {rem, 1'b0};
                    if (rr >= {1'b0, den_reg[k-1]}) begin
                        rr = rr - {1'b0, den_reg[k-1]};
                        fq = {fq[TIME_FRAC_BITS-2:0], 1'b1};
                    end else begin
                        fq = {fq[TIME_FRAC_BITS-2:0], 1'b0};
                    end
                    rem = rr[COORD_W-1:0];
                end
            end
            r_next[k]   = rem;
            fr_next[k]  = fq;
            den_next[k] = den_reg[k-1];
            ib_next[k]  = ib_reg[k-1];
            sat_next[k] = sat_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg   <= r_next;
            den_reg <= den_next;
            fr_reg  <= fr_next;
            sat_reg <= sat_next;
            ib_reg  <= ib_next;
        end
    end

    assign t_val = (sat_reg[DIV_STAGES] || (ib_reg[DIV_STAGES] && fr_reg[DIV_STAGES] != '0))
                 ? TIME_SAT : {ib_reg[DIV_STAGES], fr_reg[DIV_STAGES]};

endmodule

`default_nettype wire

// File: sv/sbsi_resolve.sv
// ----------------------------------------------------------------------------
// sbsi_resolve
// Picks the entry time and face, forms the hit point and checks it.
// ----------------------------------------------------------------------------
`default_nettype none

module sbsi_resolve import sbsi_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire side_t                    side,
    input  wire logic [2:0][TIME_W-1:0]   t_in,
    input  wire logic [MARGIN_W-1:0]      margin,
    output logic                          out_valid,
    output result_t                       res
);

    logic                     v8_reg, v9_reg, vo_reg;
    logic                     ok8_reg, ok8_next, ok9_reg;
    logic [TIME_W-1:0]        when8_reg, when8_next, when9_reg;
    logic [2:0][1:0]          nrm8_reg, nrm8_next, nrm9_reg;
    side_t                    sd8_reg, sd9_reg;
    logic [2:0][PROD_W-1:0]   prod9_reg, prod9_next;
    result_t                  res_reg, res_next;

    always_comb begin
        logic [1:0] sel;
        when8_next = t_in[2];
        sel        = 2'd2;
        if (t_in[1] > t_in[2]) begin
            when8_next = t_in[1];
            sel        = 2'd1;
        end
        if (t_in[0] > when8_next) begin
            when8_next = t_in[0];
            sel        = 2'd0;
        end
        for (int a = 0; a < 3; a++) begin
            nrm8_next[a] = (sel == 2'(a)) ? (side.face_neg[a] ? NORM_NEG : NORM_POS) : NORM_ZERO;
        end
        ok8_next = !side.miss && (side.enclosed || when8_next <= TIME_ONE);
        if (side.enclosed) begin
            when8_next = '0;
            nrm8_next  = {NORM_POS, NORM_ZERO, NORM_ZERO};
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod9_next[a] = $signed(sd8_reg.d[a]) * $signed({1'b0, when8_reg});
        end
    end

    always_comb begin
        logic [PNT_W-1:0] p, lo_m, hi_m;
        logic [SHF_W-1:0] shf;
        logic             all_in;
        all_in   = 1'b1;
        res_next = '0;
        for (int a = 0; a < 3; a++) begin
            shf  = prod9_reg[a][PROD_W-1:TIME_FRAC_BITS];
            p    = PNT_W'($signed(sd9_reg.s[a])) + PNT_W'($signed(shf));
            lo_m = PNT_W'($signed(sd9_reg.lo[a])) - PNT_W'(margin);
            hi_m = PNT_W'($signed(sd9_reg.hi[a])) + PNT_W'(margin);
            if (!($signed(p) > $signed(lo_m) && $signed(p) < $signed(hi_m))) begin
                all_in = 1'b0;
            end
            if (p[PNT_W-1:COORD_W-1] == '0 || p[PNT_W-1:COORD_W-1] == '1) begin
                res_next.pt[a] = p[COORD_W-1:0];
            end else if (p[PNT_W-1]) begin
                res_next.pt[a] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                res_next.pt[a] = {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
        res_next.hit   = ok9_reg && (sd9_reg.enclosed || all_in);
        res_next.nrm   = nrm9_reg;
        res_next.t_val = when9_reg;
        if (!res_next.hit) begin
            res_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            v8_reg <= in_valid;
            v9_reg <= v8_reg;
            vo_reg <= v9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok8_reg   <= ok8_next;
            when8_reg <= when8_next;
            nrm8_reg  <= nrm8_next;
            sd8_reg   <= side;
            ok9_reg   <= ok8_reg;
            when9_reg <= when8_reg;
            nrm9_reg  <= nrm8_reg;
            sd9_reg   <= sd8_reg;
            prod9_reg <= prod9_next;
            res_reg   <= res_next;
        end
    end

    assign out_valid = vo_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// File: sv/swept_box_segment_intersection.sv
// ----------------------------------------------------------------------------
// swept_box_segment_intersection
// An accepted input transaction passes the setup, divider and resolve registers.
// Throughput: one transaction per cycle unless stalled, set by the axis dividers.
// Output backpressure holds the whole pipeline; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) empties the pipeline and loads the box
// registers with zero and the side margin with 410.
// ----------------------------------------------------------------------------
`default_nettype none

module swept_box_segment_intersection import sbsi_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_data,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, extent_x, extent_y, extent_z
    input  wire logic [287:0]         s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, hit_time
    output logic [119:0]              m_tdata,
    // hit
    output logic                      m_tuser
);

    box_cfg_t cfg_reg;
    seg_in_t  seg;
    logic     en;
    logic     v2;
    side_t    side2;
    logic [2:0][COORD_W-1:0] num2, den2;
    logic [2:0][TIME_W-1:0]  t_div;
    side_t  [DIV_LAT-1:0]    sb_reg;
    logic   [DIV_LAT-1:0]    sbv_reg;
    result_t res;
    logic    res_valid;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            seg.start[a] = s_tdata[a*COORD_W +: COORD_W];
            seg.fin[a]   = s_tdata[(a+3)*COORD_W +: COORD_W];
            seg.ext[a]   = s_tdata[6*COORD_W + a*EXT_W +: EXT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bmin   <= '0;
            cfg_reg.bmax   <= '0;
            cfg_reg.margin <= MARGIN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BOX_MIN_X:   cfg_reg.bmin[0] <= cfg_data;
                CFG_BOX_MIN_Y:   cfg_reg.bmin[1] <= cfg_data;
                CFG_BOX_MIN_Z:   cfg_reg.bmin[2] <= cfg_data;
                CFG_BOX_MAX_X:   cfg_reg.bmax[0] <= cfg_data;
                CFG_BOX_MAX_Y:   cfg_reg.bmax[1] <= cfg_data;
                CFG_BOX_MAX_Z:   cfg_reg.bmax[2] <= cfg_data;
                CFG_SIDE_MARGIN: cfg_reg.margin  <= cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    sbsi_setup u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .seg       (seg),
        .cfg       (cfg_reg),
        .out_valid (v2),
        .side      (side2),
        .num       (num2),
        .den       (den2)
    );

    for (genvar a = 0; a < 3; a++) begin : g_div
        sbsi_div u_div (
            .aclk  (aclk),
            .en    (en),
            .num   (num2[a]),
            .den   (den2[a]),
            .t_val (t_div[a])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sbv_reg <= '0;
        end else if (en) begin
            sbv_reg <= {sbv_reg[DIV_LAT-2:0], v2};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_reg <= {sb_reg[DIV_LAT-2:0], side2};
        end
    end

    sbsi_resolve u_resolve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sbv_reg[DIV_LAT-1]),
        .side      (sb_reg[DIV_LAT-1]),
        .t_in      (t_div),
        .margin    (cfg_reg.margin),
        .out_valid (res_valid),
        .res       (res)
    );

    assign m_tvalid = res_valid;
    assign m_tuser  = res.hit;
    assign m_tdata  = {1'b0, res.t_val, res.nrm[2], res.nrm[1], res.nrm[0],
                       res.pt[2], res.pt[1], res.pt[0]};

`ifndef NO_ASSERTIONS
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("miss result carries nonzero fields");

    a_one_normal: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
        ($countones({m_tdata[97:96] != 2'b00, m_tdata[99:98] != 2'b00,
                     m_tdata[101:100] != 2'b00}) == 1))
        else $error("hit without exactly one face normal");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[118:102] <= TIME_ONE))
        else $error("hit time above one");
`endif

endmodule

`default_nettype wire
